// File: rtl/core/ncu_pkg.sv
`default_nettype none

package ncu_pkg;

    // Conversion opcodes
    typedef enum logic [3:0] {
        OP_CII = 4'd0,
        OP_CUI = 4'd1,
        OP_CFI = 4'd2,
        OP_CIF = 4'd3,
        OP_CUF = 4'd4,
        OP_CFF = 4'd5,
        OP_CIU = 4'd6,
        OP_CUU = 4'd7,
        OP_CFU = 4'd8
    } t_opcode;

    // Trap codes
    localparam logic [1:0] TRAP_NONE    = 2'd0;
    localparam logic [1:0] TRAP_ILLEGAL = 2'd1;
    localparam logic [1:0] TRAP_RANGE   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WORD_SIZE   = 2'd0;
    localparam logic [1:0] CFG_RANGE_CHECK = 2'd1;
    localparam logic [1:0] CFG_IGNORE_TRAP = 2'd2;

    // Sizes in bytes
    localparam logic [3:0] SZ_1 = 4'd1;
    localparam logic [3:0] SZ_2 = 4'd2;
    localparam logic [3:0] SZ_4 = 4'd4;
    localparam logic [3:0] SZ_8 = 4'd8;

    // Which late-stage datapath an item takes
    typedef enum logic [2:0] {
        PATH_DIRECT = 3'd0,  // result settled at decode
        PATH_F2S    = 3'd1,  // float to signed int
        PATH_F2U    = 3'd2,  // float to unsigned int
        PATH_I2F    = 3'd3,  // int to float
        PATH_S2D    = 3'd4,  // subnormal single to double
        PATH_D2S    = 3'd5   // double to single with rounding
    } t_path;

    // Decode/unpack stage payload
    typedef struct packed {
        t_path              path;
        logic [3:0]         to_size;
        logic [1:0]         trap;
        logic               chk;
        logic               sign;
        logic signed [11:0] f_exp;
        logic [52:0]        man;
        logic [63:0]        res;
        logic [31:0]        lz_in;
    } t_s1;

    // Shift/normalize stage payload
    typedef struct packed {
        t_path       path;
        logic [3:0]  to_size;
        logic [1:0]  trap;
        logic        chk;
        logic        sign;
        logic [63:0] res;
        logic [31:0] ipart;
        logic        frac;
        logic        huge;
        logic        zero;
        logic [31:0] norm;
        logic [4:0]  lz;
        logic [30:0] base;
        logic        rg;
        logic        rs;
    } t_s2;

    typedef struct packed {
        logic [4:0]  lz;
        logic [31:0] norm;
    } t_norm;

    // Leading zero count and left normalize in five halving steps
    function automatic t_norm norm32(input logic [31:0] x);
        t_norm       r;
        logic [31:0] v;
        v    = x;
        r.lz = 5'd0;
        if (v[31:16] == 16'h0) begin
            r.lz[4] = 1'b1;
            v       = {v[15:0], 16'h0};
        end
        if (v[31:24] == 8'h0) begin
            r.lz[3] = 1'b1;
            v       = {v[23:0], 8'h0};
        end
        if (v[31:28] == 4'h0) begin
            r.lz[2] = 1'b1;
            v       = {v[27:0], 4'h0};
        end
        if (v[31:30] == 2'h0) begin
            r.lz[1] = 1'b1;
            v       = {v[29:0], 2'h0};
        end
        if (v[31] == 1'b0) begin
            r.lz[0] = 1'b1;
            v       = {v[30:0], 1'b0};
        end
        r.norm = v;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/numeric_conversion_unit_top.sv
// Integer/float size conversion unit. Each input beat carries an opcode (CII, CUI, CFI,
// CIF, CUF, CFF, CIU, CUU, CFU), source and destination sizes in bytes and the raw
// operand; each beat yields exactly one output beat with the converted bits, the result
// size, and a trap code (illegal pair or range error; on a trap result and size are 0).
// The datapath is a three-stage pipeline: decode/unpack, shift/normalize, round/pack
// into the output register. One beat is accepted every cycle unless o_in_stall is high; a
// stall on the output only holds the stages that are full, so bubbles are squeezed out. The
// user must write configuration through the cfg port (always ready) only while idle; the block does not enforce it.
`default_nettype none

module numeric_conversion_unit_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [3:0]  i_from_size,
    input  wire logic [3:0]  i_to_size,
    input  wire logic [63:0] i_operand,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [63:0]      o_result,
    output logic [3:0]       o_result_size,
    output logic [1:0]       o_trap_code,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [2:0]  i_cfg_data
);

    // configuration registers
    logic [2:0] r_word_size;
    logic       r_range_chk;
    logic       r_ign_trap;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_size <= 3'd4;
            r_range_chk <= 1'b0;
            r_ign_trap  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ncu_pkg::CFG_WORD_SIZE:   r_word_size <= i_cfg_data;
                ncu_pkg::CFG_RANGE_CHECK: r_range_chk <= i_cfg_data[0];
                ncu_pkg::CFG_IGNORE_TRAP: r_ign_trap  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline flow control: a stage moves when it is empty or the next one moves
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3        = !r_v3 || !i_out_stall;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: decode, legality, integer conversions, float unpack
    // ------------------------------------------------------------------
    ncu_pkg::t_s1 n_s1, r_s1;

    logic [7:0]  pair;
    logic        legal, short_pair, chk;
    logic [31:0] src_s, src_u, mag;
    logic        u_sign;
    logic        ef_zero, ef_all1, mf_zero;
    logic [63:0] x;

    assign x    = i_operand;
    assign pair = {i_from_size, i_to_size};
    assign chk  = r_range_chk && !r_ign_trap;

    always_comb begin
        // legal size pairs per opcode
        legal      = 1'b0;
        short_pair = 1'b0;
        case (i_opcode)
            ncu_pkg::OP_CII: begin
                legal      = pair inside {8'h12, 8'h14, 8'h22, 8'h24, 8'h42, 8'h44};
                short_pair = (i_to_size == ncu_pkg::SZ_2);
            end
            ncu_pkg::OP_CUI, ncu_pkg::OP_CIU, ncu_pkg::OP_CUU: begin
                legal      = pair inside {8'h22, 8'h24, 8'h42, 8'h44};
                short_pair = (pair != 8'h44);
            end
            ncu_pkg::OP_CFI, ncu_pkg::OP_CFU: begin
                legal      = pair inside {8'h42, 8'h44, 8'h82, 8'h84};
                short_pair = (i_to_size == ncu_pkg::SZ_2);
            end
            ncu_pkg::OP_CIF, ncu_pkg::OP_CUF: begin
                legal      = pair inside {8'h24, 8'h28, 8'h44, 8'h48};
                short_pair = (i_from_size == ncu_pkg::SZ_2);
            end
            ncu_pkg::OP_CFF: begin
                legal      = pair inside {8'h44, 8'h48, 8'h84, 8'h88};
                short_pair = 1'b0;
            end
            default: begin
                legal      = 1'b0;
                short_pair = 1'b0;
            end
        endcase

        // integer sources
        case (i_from_size)
            ncu_pkg::SZ_1: src_s = {{24{x[7]}}, x[7:0]};
            ncu_pkg::SZ_2: src_s = {{16{x[15]}}, x[15:0]};
            default:       src_s = x[31:0];
        endcase
        src_u = (i_from_size == ncu_pkg::SZ_2) ? {16'h0, x[15:0]} : x[31:0];

        // float unpack: value = man * 2^(f_exp - 52)
        n_s1 = '0;
        if (i_from_size == ncu_pkg::SZ_4) begin
            ef_zero       = (x[30:23] == 8'h00);
            ef_all1       = (x[30:23] == 8'hff);
            mf_zero       = (x[22:0] == 23'h0);
            n_s1.sign     = x[31];
            n_s1.f_exp    = ef_zero ? -12'sd126 : $signed({4'b0, x[30:23]}) - 12'sd127;
            n_s1.man      = {!ef_zero, x[22:0], 29'h0};
        end else begin
            ef_zero       = (x[62:52] == 11'h000);
            ef_all1       = (x[62:52] == 11'h7ff);
            mf_zero       = (x[51:0] == 52'h0);
            n_s1.sign     = x[63];
            n_s1.f_exp    = ef_zero ? -12'sd1022 : $signed({1'b0, x[62:52]}) - 12'sd1023;
            n_s1.man      = {!ef_zero, x[51:0]};
        end

        // int to float magnitude
        if (i_opcode == ncu_pkg::OP_CIF) begin
            u_sign = src_s[31];
            mag    = src_s[31] ? (32'h0 - src_s) : src_s;
        end else begin
            u_sign = 1'b0;
            mag    = src_u;
        end

        n_s1.to_size = i_to_size;
        n_s1.chk     = chk;
        n_s1.path    = ncu_pkg::PATH_DIRECT;
        n_s1.trap    = ncu_pkg::TRAP_NONE;
        n_s1.res     = '0;
        n_s1.lz_in   = '0;

        if (!legal || (short_pair && r_word_size == 3'd4)) begin
            n_s1.trap = ncu_pkg::TRAP_ILLEGAL;
        end else begin
            case (i_opcode)
                ncu_pkg::OP_CII: begin
                    if (chk && i_from_size == ncu_pkg::SZ_4 && i_to_size == ncu_pkg::SZ_2
                        && !((&src_s[31:15]) || !(|src_s[31:15])))
                        n_s1.trap = ncu_pkg::TRAP_RANGE;
                    n_s1.res = (i_to_size == ncu_pkg::SZ_2) ? {{48{src_s[15]}}, src_s[15:0]}
                                                            : {{32{src_s[31]}}, src_s};
                end
                ncu_pkg::OP_CUI: begin
                    if (chk && ((i_to_size == ncu_pkg::SZ_2 && src_u[31:15] != 17'h0)
                        || (i_to_size == ncu_pkg::SZ_4 && i_from_size == ncu_pkg::SZ_4
                            && src_u[31])))
                        n_s1.trap = ncu_pkg::TRAP_RANGE;
                    n_s1.res = (i_to_size == ncu_pkg::SZ_2) ? {{48{src_u[15]}}, src_u[15:0]}
                                                            : {{32{src_u[31]}}, src_u};
                end
                ncu_pkg::OP_CIU, ncu_pkg::OP_CUU: begin
                    n_s1.res = (i_from_size == ncu_pkg::SZ_2 || i_to_size == ncu_pkg::SZ_2)
                             ? {48'h0, x[15:0]} : {32'h0, x[31:0]};
                end
                ncu_pkg::OP_CFI, ncu_pkg::OP_CFU: begin
                    // NaN converts to zero without a trap
                    if (!(ef_all1 && !mf_zero))
                        n_s1.path = (i_opcode == ncu_pkg::OP_CFI) ? ncu_pkg::PATH_F2S
                                                                  : ncu_pkg::PATH_F2U;
                end
                ncu_pkg::OP_CIF, ncu_pkg::OP_CUF: begin
                    n_s1.path  = ncu_pkg::PATH_I2F;
                    n_s1.sign  = u_sign;
                    n_s1.lz_in = mag;
                end
                ncu_pkg::OP_CFF: begin
                    if (i_from_size == i_to_size) begin
                        n_s1.res = (i_from_size == ncu_pkg::SZ_4) ? {32'h0, x[31:0]} : x;
                    end else if (i_to_size == ncu_pkg::SZ_8) begin
                        // single to double
                        if (ef_all1 && !mf_zero)
                            n_s1.res = {x[31], 11'h7ff, 1'b1, x[21:0] | 22'h0, 29'h0}
                                     | {12'h0, x[22:0], 29'h0};
                        else if (ef_all1)
                            n_s1.res = {x[31], 11'h7ff, 52'h0};
                        else if (ef_zero && mf_zero)
                            n_s1.res = {x[31], 63'h0};
                        else if (!ef_zero)
                            n_s1.res = {x[31], {3'b0, x[30:23]} + 11'd896, x[22:0], 29'h0};
                        else begin
                            n_s1.path  = ncu_pkg::PATH_S2D;
                            n_s1.lz_in = {x[22:0], 9'h0};
                        end
                    end else begin
                        // double to single
                        if (ef_all1 && !mf_zero)
                            n_s1.res = {32'h0, x[63], 8'hff, 1'b1, x[50:29]};
                        else
                            n_s1.path = ncu_pkg::PATH_D2S;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_s1 <= n_s1;
    end

    // ------------------------------------------------------------------
    // Stage 2: right shifts for float to int and double to single,
    //          normalize for int to float and subnormal single
    // ------------------------------------------------------------------
    ncu_pkg::t_s2   n_s2, r_s2;
    ncu_pkg::t_norm nrm;
    logic signed [11:0] e2;
    logic [11:0]        sh_i, sh_d;
    logic [52:0]        shr_i;
    logic [127:0]       shr_d;

    always_comb begin
        e2  = r_s1.f_exp;
        nrm = ncu_pkg::norm32(r_s1.lz_in);

        n_s2         = '0;
        n_s2.path    = r_s1.path;
        n_s2.to_size = r_s1.to_size;
        n_s2.trap    = r_s1.trap;
        n_s2.chk     = r_s1.chk;
        n_s2.sign    = r_s1.sign;
        n_s2.res     = r_s1.res;
        n_s2.norm    = nrm.norm;
        n_s2.lz      = nrm.lz;
        n_s2.zero    = (r_s1.lz_in == 32'h0);

        // float to int: integer part and lost fraction
        sh_i  = 12'(12'sd52 - e2);
        shr_i = r_s1.man >> sh_i[5:0];
        if (e2 < 12'sd0) begin
            n_s2.ipart = 32'h0;
            n_s2.frac  = (r_s1.man != 53'h0);
            n_s2.huge  = 1'b0;
        end else if (e2 >= 12'sd32) begin
            n_s2.ipart = 32'h0;
            n_s2.frac  = 1'b0;
            n_s2.huge  = 1'b1;
        end else begin
            n_s2.ipart = shr_i[31:0];
            n_s2.frac  = ((shr_i << sh_i[5:0]) != r_s1.man);
            n_s2.huge  = 1'b0;
        end

        // double to single: pre-rounding {exp, mantissa}, guard and sticky
        sh_d  = (e2 < -12'sd160) ? 12'd63 : 12'(-12'sd97 - e2);
        shr_d = {r_s1.man, 75'h0} >> sh_d[5:0];
        if (e2 > 12'sd127) begin
            n_s2.base = {8'hff, 23'h0};
            n_s2.rg   = 1'b0;
            n_s2.rs   = 1'b0;
        end else if (e2 >= -12'sd126) begin
            n_s2.base = {8'(e2 + 12'sd127), r_s1.man[51:29]};
            n_s2.rg   = r_s1.man[28];
            n_s2.rs   = |r_s1.man[27:0];
        end else begin
            n_s2.base = {8'h0, shr_d[97:75]};
            n_s2.rg   = shr_d[74];
            n_s2.rs   = |shr_d[73:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) r_s2 <= n_s2;
    end

    // ------------------------------------------------------------------
    // Stage 3: saturate/range check, round, pack into output register
    // ------------------------------------------------------------------
    logic [63:0] n_res, r_res;
    logic [1:0]  n_trap, r_trap;
    logic [3:0]  r_size;
    logic [31:0] k_half, k_mag, f_mag;
    logic        ge_k, ge_k1, over_hi;
    logic [30:0] rb, rsum;
    logic        rgb, rsb, rup;

    always_comb begin
        // float to int limits
        k_half  = (r_s2.to_size == ncu_pkg::SZ_2) ? 32'h0000_8000 : 32'h8000_0000;
        ge_k    = r_s2.huge || (r_s2.ipart >= k_half);
        ge_k1   = r_s2.huge || (r_s2.ipart > k_half);
        over_hi = ge_k || (r_s2.ipart == k_half - 32'd1 && r_s2.frac);
        if (!r_s2.sign)
            k_mag = ge_k ? (k_half - 32'd1) : r_s2.ipart;
        else
            k_mag = ge_k1 ? k_half : r_s2.ipart;

        if (r_s2.sign)
            f_mag = 32'h0;
        else if (r_s2.huge)
            f_mag = (r_s2.to_size == ncu_pkg::SZ_2) ? 32'h0000_ffff : 32'hffff_ffff;
        else if (r_s2.to_size == ncu_pkg::SZ_2 && r_s2.ipart[31:16] != 16'h0)
            f_mag = 32'h0000_ffff;
        else
            f_mag = r_s2.ipart;

        // shared round-to-nearest-even adder for single results
        if (r_s2.path == ncu_pkg::PATH_I2F) begin
            rb  = {8'(8'd158 - {3'b0, r_s2.lz}), r_s2.norm[30:8]};
            rgb = r_s2.norm[7];
            rsb = |r_s2.norm[6:0];
        end else begin
            rb  = r_s2.base;
            rgb = r_s2.rg;
            rsb = r_s2.rs;
        end
        rup  = rgb && (rsb || rb[0]);
        rsum = rb + {30'h0, rup};

        n_trap = r_s2.trap;
        case (r_s2.path)
            ncu_pkg::PATH_DIRECT: n_res = r_s2.res;
            ncu_pkg::PATH_F2S: begin
                if (r_s2.chk && (r_s2.sign ? ge_k1 : over_hi))
                    n_trap = ncu_pkg::TRAP_RANGE;
                n_res = r_s2.sign ? (64'h0 - {32'h0, k_mag}) : {32'h0, k_mag};
            end
            ncu_pkg::PATH_F2U: n_res = {32'h0, f_mag};
            ncu_pkg::PATH_I2F: begin
                if (r_s2.zero)
                    n_res = 64'h0;
                else if (r_s2.to_size == ncu_pkg::SZ_8)
                    n_res = {r_s2.sign, 11'(11'd1054 - {6'b0, r_s2.lz}),
                             r_s2.norm[30:0], 21'h0};
                else
                    n_res = {32'h0, r_s2.sign, rsum};
            end
            ncu_pkg::PATH_S2D:
                n_res = {r_s2.sign, 11'(11'd896 - {6'b0, r_s2.lz}), r_s2.norm[30:0], 21'h0};
            ncu_pkg::PATH_D2S: n_res = {32'h0, r_s2.sign, rsum};
            default:           n_res = r_s2.res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_trap <= n_trap;
            r_res  <= (n_trap != ncu_pkg::TRAP_NONE) ? 64'h0 : n_res;
            r_size <= (n_trap != ncu_pkg::TRAP_NONE) ? 4'h0 : r_s2.to_size;
        end
    end

    assign o_out_valid   = r_v3;
    assign o_result      = r_res;
    assign o_result_size = r_size;
    assign o_trap_code   = r_trap;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_trap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_trap_code != ncu_pkg::TRAP_NONE)
            |-> (o_result == 64'h0 && o_result_size == 4'h0))
        else $error("trapped beat carries data");

    a_size_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_trap_code == ncu_pkg::TRAP_NONE)
            |-> (o_result_size == ncu_pkg::SZ_2 || o_result_size == ncu_pkg::SZ_4
                 || o_result_size == ncu_pkg::SZ_8))
        else $error("bad result size");

    a_no_stall_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output stage");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_v3 && i_out_stall) |=> r_v2)
        else $error("stage 2 item lost under stall");

endmodule

`default_nettype wire
